/* rtl/dpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the Magnus dew point pipeline.
// ----------------------------------------------------------------------------
package dpm_pkg;

  // Fixed-point format of temperature, humidity and dew point
  localparam int FRAC_BITS = 8;

  // Magnus constants: b scaled by 1000, c scaled by 100
  localparam int BN_POS = 17368;
  localparam int CN_POS = 23888;
  localparam int BN_NEG = 17966;
  localparam int CN_NEG = 24715;

  // ln(2) in Q30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Pipeline depths
  localparam int RDIV_STAGES = 31;   // ratio quotient bits
  localparam int DDIV_STAGES = 17;   // dew point quotient bits
  localparam int LOG_LAT     = 30;   // dpm_log2 input to output registers

  // Input transfer payload
  typedef struct packed {
    logic signed [15:0] temperature;
    logic [14:0]        humidity;
  } dpm_in_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [15:0] dew_point;
    logic               valid_res;
  } dpm_out_t;

  // Flags carried beside the ratio divider
  typedef struct packed {
    logic hz;     // humidity was zero
    logic pos;    // temperature above zero
    logic tneg;   // temperature below zero
  } dpm_side_t;

  // Flags carried beside the dew point divider
  typedef struct packed {
    logic hz;
    logic neg;    // quotient is negative
    logic ovf;    // quotient beyond 16-bit range
  } dpm_dside_t;

  // log2 in Q26 by repeated squaring, evaluated at elaboration only
  function automatic logic [31:0] log2_q26(input logic [31:0] x);
    logic [63:0] m;
    logic [31:0] fr;
    int          e;
    e = 0;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) e = b;
    end
    m  = 64'(x) << (30 - e);
    fr = '0;
    for (int i = 0; i < 26; i++) begin
      m  = (m * m) >> 30;
      fr = {fr[30:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m     = m >> 1;
        fr[0] = 1'b1;
      end
    end
    return (32'(e) << 26) | fr;
  endfunction

  // log2 of 100 percent in the input format
  localparam logic [31:0] LOG100_Q26 = log2_q26(32'(100) << FRAC_BITS);

endpackage

/* rtl/dew_point_magnus_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_point_magnus_core
// Magnus dew point from temperature and relative humidity, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one temperature and humidity sample
//   (signed and unsigned, 8 fraction bits). out_valid/out_ready/out_data
//   carry the dew point (same format, saturated) and valid_res, which is
//   low with a zero dew point when humidity was zero.
//   From input transfer to out_valid, a sample passes the input register,
//   the bit-per-stage ratio divider (31 stages behind the input register),
//   gamma, the product stage, the dew point divider (17 stages behind its
//   input register) and the output register. The squaring log2 chain
//   (26 stages) runs beside the ratio divider. One sample is taken every
//   cycle unless the pipeline holds, as all stages advance together.
//   The whole pipeline holds when a result waits and out_ready is low;
//   in_ready then drops, nothing is lost or repeated. Holes in the input
//   stream travel as empty stages.
//   Reset (rst_n low, synchronous) clears every stage valid bit; no
//   result is pending afterwards.
// ----------------------------------------------------------------------------
module dew_point_magnus_core
  import dpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dpm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dpm_out_t out_data
);

  localparam int LN_PAD = 1 + RDIV_STAGES - LOG_LAT;

  localparam logic signed [31:0] CNQ_POS  = 32'(CN_POS * (2 ** FRAC_BITS));
  localparam logic signed [31:0] CNQ_NEG  = 32'(CN_NEG * (2 ** FRAC_BITS));
  localparam logic signed [50:0] CN10_POS = 51'(CN_POS * 10);
  localparam logic signed [50:0] CN10_NEG = 51'(CN_NEG * 10);
  localparam logic signed [44:0] BNQ_POS  = 45'(BN_POS) <<< 24;
  localparam logic signed [44:0] BNQ_NEG  = 45'(BN_NEG) <<< 24;

  logic en;
  logic vo_r;

  // Pipeline advances unless the output holds an untaken result
  assign en        = !vo_r || out_ready;
  assign in_ready  = en;
  assign out_valid = vo_r;

  // Input stage: numerator b*|t| and denominator 10*(c*2^F + 100*t)
  logic signed [15:0] t_in;
  logic               pos_a, tneg_a;
  logic [15:0]        tmag_a;
  logic [14:0]        bn_a;
  logic [30:0]        n1_a;
  logic signed [31:0] den_a;

  assign t_in   = in_data.temperature;
  assign pos_a  = t_in > 16'sd0;
  assign tneg_a = t_in[15];
  assign tmag_a = tneg_a ? (~t_in + 16'd1) : t_in;
  assign bn_a   = pos_a ? 15'(BN_POS) : 15'(BN_NEG);
  assign n1_a   = bn_a * tmag_a;
  assign den_a  = 32'sd10 * ((pos_a ? CNQ_POS : CNQ_NEG) + 32'sd100 * 32'(t_in));

  // Ratio divider: restoring, one quotient bit per stage
  logic [26:0] r1_r  [0:RDIV_STAGES];
  logic [26:0] d1_r  [0:RDIV_STAGES];
  logic [30:0] q1_r  [0:RDIV_STAGES];
  logic [5:0]  nl1_r [0:RDIV_STAGES];
  dpm_side_t   s1_r  [0:RDIV_STAGES];
  logic        v1_r  [0:RDIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r[0]  <= 27'(n1_a[30:6]);
      d1_r[0]  <= den_a[26:0];
      q1_r[0]  <= '0;
      nl1_r[0] <= n1_a[5:0];
      s1_r[0]  <= '{hz: in_data.humidity == 15'd0, pos: pos_a, tneg: tneg_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r[0] <= 1'b0;
    end else if (en) begin
      v1_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < RDIV_STAGES; i++) begin : g_rdiv
    logic        nb;
    logic [27:0] rs;
    logic        ge;
    if (i < 6) begin : g_nb
      assign nb = nl1_r[i][5-i];
    end else begin : g_nz
      assign nb = 1'b0;
    end
    assign rs = {r1_r[i], nb};
    assign ge = rs >= {1'b0, d1_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r1_r[i+1]  <= ge ? 27'(rs - {1'b0, d1_r[i]}) : rs[26:0];
        d1_r[i+1]  <= d1_r[i];
        q1_r[i+1]  <= {q1_r[i][29:0], ge};
        nl1_r[i+1] <= nl1_r[i];
        s1_r[i+1]  <= s1_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[i+1] <= 1'b0;
      end else if (en) begin
        v1_r[i+1] <= v1_r[i];
      end
    end
  end

  // Log path, padded to meet the ratio quotient
  logic signed [29:0] ln_out;
  logic signed [29:0] lnd_r [0:LN_PAD-1];

  dpm_log2 u_log2 (
    .clk      (clk),
    .en       (en),
    .humidity (in_data.humidity),
    .ln_q24   (ln_out)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lnd_r[0] <= ln_out;
      for (int k = 1; k < LN_PAD; k++) lnd_r[k] <= lnd_r[k-1];
    end
  end

  // Gamma = rounded ratio + ln
  logic [31:0]        ratio_u;
  logic signed [32:0] ratio_s;
  logic signed [32:0] g_r;
  logic               pos_g_r, hz_g_r, v_g_r;

  assign ratio_u = ({1'b0, q1_r[RDIV_STAGES]} + 32'd1) >> 1;
  assign ratio_s = s1_r[RDIV_STAGES].tneg ? -$signed({1'b0, ratio_u}) : $signed({1'b0, ratio_u});

  always_ff @(posedge clk) begin
    if (en) begin
      g_r     <= ratio_s + 33'(lnd_r[LN_PAD-1]);
      pos_g_r <= s1_r[RDIV_STAGES].pos;
      hz_g_r  <= s1_r[RDIV_STAGES].hz;
    end
  end

  // Numerator 10*c*g and denominator b*2^24 - 1000*g
  logic signed [50:0] nn_r;
  logic signed [44:0] dd_r;
  logic               hz_m_r, v_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r   <= 51'(g_r) * (pos_g_r ? CN10_POS : CN10_NEG);
      dd_r   <= (pos_g_r ? BNQ_POS : BNQ_NEG) - 45'(g_r) * 45'sd1000;
      hz_m_r <= hz_g_r;
    end
  end

  // Magnitudes, sign and range check ahead of the second divider
  logic [50:0] nnm;
  logic [44:0] ddm;
  logic        ovf_n;

  assign nnm   = nn_r[50] ? 51'(-nn_r) : 51'(nn_r);
  assign ddm   = dd_r[44] ? 45'(-dd_r) : 45'(dd_r);
  assign ovf_n = (nnm >> 8) >= 51'(ddm);

  logic [44:0] r2_r  [0:DDIV_STAGES];
  logic [44:0] d2_r  [0:DDIV_STAGES];
  logic [16:0] q2_r  [0:DDIV_STAGES];
  logic [7:0]  nl2_r [0:DDIV_STAGES];
  dpm_dside_t  s2_r  [0:DDIV_STAGES];
  logic        v2_r  [0:DDIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r[0]  <= ovf_n ? '0 : {2'b00, nnm[50:8]};
      d2_r[0]  <= ddm;
      q2_r[0]  <= '0;
      nl2_r[0] <= nnm[7:0];
      s2_r[0]  <= '{hz: hz_m_r, neg: nn_r[50] ^ dd_r[44], ovf: ovf_n};
    end
  end

  // Dew point divider: 17 quotient bits of nn*2^9/dd
  for (genvar i = 0; i < DDIV_STAGES; i++) begin : g_ddiv
    logic        nb;
    logic [45:0] rs;
    logic        ge;
    if (i < 8) begin : g_nb
      assign nb = nl2_r[i][7-i];
    end else begin : g_nz
      assign nb = 1'b0;
    end
    assign rs = {r2_r[i], nb};
    assign ge = rs >= {1'b0, d2_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        r2_r[i+1]  <= ge ? 45'(rs - {1'b0, d2_r[i]}) : rs[44:0];
        d2_r[i+1]  <= d2_r[i];
        q2_r[i+1]  <= {q2_r[i][15:0], ge};
        nl2_r[i+1] <= nl2_r[i];
        s2_r[i+1]  <= s2_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[i+1] <= 1'b0;
      end else if (en) begin
        v2_r[i+1] <= v2_r[i];
      end
    end
  end

  // Round, sign, saturate into the output register
  logic [17:0] mag_w;
  logic [16:0] mag;
  dpm_side_t   sf;
  dpm_dside_t  df;
  dpm_out_t    out_nxt;

  assign sf    = s1_r[RDIV_STAGES];
  assign df    = s2_r[DDIV_STAGES];
  assign mag_w = (18'(q2_r[DDIV_STAGES]) + 18'd1) >> 1;
  assign mag   = mag_w[16:0];

  always_comb begin
    out_nxt.valid_res = !df.hz;
    if (df.hz) begin
      out_nxt.dew_point = '0;
    end else if (df.neg) begin
      out_nxt.dew_point = (df.ovf || mag >= 17'd32768) ? 16'sh8000 : 16'(-mag);
    end else begin
      out_nxt.dew_point = (df.ovf || mag > 17'd32767) ? 16'sh7FFF : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_nxt;
    end
  end

  // Valid bits of the single stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r   <= 1'b0;
      v_m_r   <= 1'b0;
      v2_r[0] <= 1'b0;
      vo_r    <= 1'b0;
    end else if (en) begin
      v_g_r   <= v1_r[RDIV_STAGES] && (sf.hz || !sf.hz);
      v_m_r   <= v_g_r;
      v2_r[0] <= v_m_r;
      vo_r    <= v2_r[DDIV_STAGES];
    end
  end

endmodule

/* rtl/dpm_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_log2
// Pipelined ln(RH/100) in Q24: normalize, 26 squaring stages, scale by ln 2.
// ----------------------------------------------------------------------------
module dpm_log2
  import dpm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [14:0]        humidity,
  output logic signed [29:0] ln_q24
);

  // Normalize: msb index and Q30 mantissa
  logic [3:0]  e_nxt;
  logic [30:0] m_nxt;

  always_comb begin
    e_nxt = '0;
    for (int b = 0; b < 15; b++) begin
      if (humidity[b]) e_nxt = 4'(b);
    end
    m_nxt = 31'(humidity) << (5'd30 - 5'(e_nxt));
  end

  logic [30:0] m_r  [0:26];
  logic [25:0] fr_r [0:26];
  logic [3:0]  e_r  [0:26];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= m_nxt;
      fr_r[0] <= '0;
      e_r[0]  <= e_nxt;
    end
  end

  // One fraction bit per stage: square, renormalize
  for (genvar k = 0; k < 26; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = m_r[k] * m_r[k];
    assign sh = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1]  <= sh[31] ? sh[31:1] : sh[30:0];
        fr_r[k+1] <= {fr_r[k][24:0], sh[31]};
        e_r[k+1]  <= e_r[k];
      end
    end
  end

  // Subtract log2(100%), then scale magnitude by ln 2 and round
  logic signed [31:0] dl_nxt;
  logic [29:0]        dlm_r;
  logic               dneg_r;
  logic [59:0]        p_r;
  logic               pneg_r;
  logic [60:0]        pr;

  assign dl_nxt = $signed({2'b00, e_r[26], fr_r[26]}) - $signed(LOG100_Q26);
  assign pr     = 61'(p_r) + (61'd1 << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r <= dl_nxt[31];
      dlm_r  <= dl_nxt[31] ? 30'(-dl_nxt) : dl_nxt[29:0];
      p_r    <= dlm_r * LN2_Q30;
      pneg_r <= dneg_r;
      ln_q24 <= pneg_r ? -$signed({1'b0, pr[60:32]}) : $signed({1'b0, pr[60:32]});
    end
  end

endmodule

/* rtl/dpm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_checker
// Port-level checks of the dew point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dpm_checker
  import dpm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input dpm_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input dpm_out_t out_data
);

  // A stalled result holds its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Undefined results carry a zero dew point
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.dew_point == 16'sd0)
    else $error("invalid result with nonzero dew point");

  // An empty output never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Reset leaves no pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A blocked input sample waits unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input sample changed while blocked");

endmodule

bind dew_point_magnus_core dpm_checker u_dpm_checker (.*);
